>>> hw/rtl/serial_packet_deframer_top_defines.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; files that assert include this header by name.
`ifndef SERIAL_PACKET_DEFRAMER_TOP_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define SPD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("deframer assertion failed");

// Condition must never be true at a clock edge outside reset.
`define SPD_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("deframer forbidden condition seen");

`else

`define SPD_ASSERT(label, clk, rst_n, prop)
`define SPD_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> hw/rtl/spd_pkg.sv
// Types, constants and checksum function of the serial packet deframer.
// No dependencies; used by the parser and the top level.
package spd_pkg;

	// Frame start byte and the left shift that forms a rotate right by one.
	localparam logic [7:0] FRAME_START = 8'hCC;
	localparam int unsigned ROT_AMT = 7;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_DATA   = 2'd1,
		KIND_ACCEPT = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_IDLE    = 6'b000001,
		PH_LEN     = 6'b000010,
		PH_ID      = 6'b000100,
		PH_PAYLOAD = 6'b001000,
		PH_CHECK   = 6'b010000,
		PH_TRAILER = 6'b100000
	} phase_t;

	// One result item as produced by the parser.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [7:0] packet_id;
		logic [7:0] packet_length;
	} spd_result_t;

	// Rotate the running sum right by one bit, then add the byte modulo 256.
	function automatic logic [7:0] sum_update(input logic [7:0] sum, input logic [7:0] b);
		logic [7:0] rot;
		rot = (sum >> 1) | (sum << ROT_AMT);
		return rot + b;
	endfunction

endpackage

>>> hw/rtl/spd_if.sv
// Valid/ready channel interfaces of the deframer: received bytes in, results out.
// Depends on nothing but the field widths of the block.
interface spd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic [7:0] packet_id;
	logic [7:0] packet_length;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output packet_id, output packet_length, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input packet_id, input packet_length, output ready);
endinterface

>>> hw/rtl/spd_parser.sv
// Frame parser state machine: holds the frame state and forms one result per byte.
// Depends on spd_pkg for the phase and result types and the checksum function.
module spd_parser
	import spd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	output spd_result_t res
);

	phase_t     phase_q, phase_d;
	logic [7:0] length_q, length_d;
	logic [7:0] id_q, id_d;
	logic [7:0] count_q, count_d;
	logic [7:0] sum_q, sum_d;
	kind_t      kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;

	// Next state and result for the byte presented this cycle.
	always_comb begin
		phase_d    = phase_q;
		length_d   = length_q;
		id_d       = id_q;
		count_d    = count_q;
		sum_d      = sum_q;
		kind       = KIND_NONE;
		data_byte  = 8'd0;
		byte_index = 8'd0;
		unique case (phase_q)
			PH_LEN: begin
				length_d = rx_byte;
				phase_d  = PH_ID;
			end
			PH_ID: begin
				id_d    = rx_byte;
				sum_d   = sum_update(sum_q, rx_byte);
				// An empty payload goes straight to the checksum byte.
				phase_d = (length_q == 8'd0) ? PH_CHECK : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				kind       = KIND_DATA;
				data_byte  = rx_byte;
				byte_index = count_q;
				sum_d      = sum_update(sum_q, rx_byte);
				count_d    = count_q + 8'd1;
				if (count_d >= length_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (rx_byte == sum_q) begin
					phase_d = PH_TRAILER;
				end else begin
					kind    = KIND_REJECT;
					phase_d = PH_IDLE;
				end
				sum_d = 8'd0;
			end
			PH_TRAILER: begin
				// Any byte value closes a good frame.
				kind    = KIND_ACCEPT;
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
				if (rx_byte == FRAME_START) begin
					sum_d   = 8'd0;
					count_d = 8'd0;
					phase_d = PH_LEN;
				end
			end
		endcase
	end

	// Frame state advances only when the byte moves on to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			length_q <= 8'd0;
			id_q     <= 8'd0;
			count_q  <= 8'd0;
			sum_q    <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			id_q     <= id_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
		end
	end

	assign res.kind          = kind;
	assign res.data_byte     = data_byte;
	assign res.byte_index    = byte_index;
	assign res.packet_id     = id_d;
	assign res.packet_length = length_d;

endmodule

>>> hw/rtl/serial_packet_deframer_top.sv
// Serial packet deframer top level: input register, parser, result register.
// Depends on spd_pkg, the channel interfaces in spd_if.sv and spd_parser.
//
// The block takes received bytes and parses frames of the form header 0xCC,
// length, ID, payload, checksum, trailer, where the checksum rotates right by
// one and adds each ID and payload byte. Every accepted byte gives exactly one
// result item: kind 0 for nothing, 1 for a payload byte with its index, 2 for
// an accepted packet (on the trailer byte), 3 for a checksum mismatch; the
// packet ID and length of the current or most recent frame ride along. One
// byte is taken every cycle while results are drained; each byte passes
// through the input register and then the result register, with the frame
// state updated in a single step as a byte passes between them. A stalled
// result side backs up through both registers before ready drops.
`include "serial_packet_deframer_top_defines.svh"

module serial_packet_deframer_top
	import spd_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	spd_byte_if.sink     byte_in,
	spd_result_if.source result_out
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	spd_result_t res_s2;
	spd_result_t res;
	logic        out_free;
	logic        advance;

	// Result register can take a new item when empty or being drained.
	assign out_free      = !valid_s2 || result_out.ready;
	assign advance       = valid_s1 && out_free;
	assign byte_in.ready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.rx_byte;
		end
	end

	spd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign result_out.valid         = valid_s2;
	assign result_out.kind          = res_s2.kind;
	assign result_out.data_byte     = res_s2.data_byte;
	assign result_out.byte_index    = res_s2.byte_index;
	assign result_out.packet_id     = res_s2.packet_id;
	assign result_out.packet_length = res_s2.packet_length;

	// A payload byte always lies inside the announced length.
	`SPD_ASSERT(a_index_in_range, clk, arst_n, (valid_s2 && res_s2.kind == KIND_DATA) |-> (res_s2.byte_index < res_s2.packet_length))
	// Items other than payload bytes carry zero data and index.
	`SPD_ASSERT(a_idle_fields_zero, clk, arst_n, (valid_s2 && res_s2.kind != KIND_DATA) |-> (res_s2.data_byte == 8'd0 && res_s2.byte_index == 8'd0))
	// A byte held in the input register waits there while the result side stalls.
	`SPD_ASSERT(a_s1_holds, clk, arst_n, (valid_s1 && !out_free) |=> (valid_s1 && $stable(byte_s1)))
	// The parser never steps without a byte in the input register.
	`SPD_NEVER(a_step_needs_byte, clk, arst_n, advance && !valid_s1)

endmodule
